FILE: rtl/sha256_pkg.sv
// SHA-256 stream hasher: shared types, constants and a rotate function.
// No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    typedef struct packed {
        logic       start_block;  // copy H into a..h
        logic       round_en;     // run one round
        logic       fold;         // add a..h into H
        logic       reset_chain;  // H back to initial values
    } sha_cmd_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: rtl/sha256_datapath.sv
// SHA-256 compression datapath: schedule window (also holds the incoming
// block bytes), working registers, chain value. Depends on sha256_pkg.
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    input  logic        byte_we,       // write one byte into the block buffer
    input  logic [5:0]  byte_addr,
    input  logic [7:0]  byte_data,
    input  logic [5:0]  round_idx,
    input  logic [2:0]  out_sel,
    output logic [31:0] out_word
);

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] h0_reg [8];

    logic [31:0] w_new, w_cur, t1, t2, s0, s1, ep0, ep1, ch, maj;

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        // first 16 rounds rotate the loaded words through index 0
        w_cur = (round_idx < 6'd16) ? w_reg[0] : w_new;
        ep1 = rotr(e_reg, 6) ^ rotr(e_reg, 11) ^ rotr(e_reg, 25);
        ch  = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1  = h_reg + ep1 + ch + ROUND_K[round_idx] + w_cur;
        ep0 = rotr(a_reg, 2) ^ rotr(a_reg, 13) ^ rotr(a_reg, 22);
        maj = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2  = ep0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            // byte k lands big-endian in word k/4
            w_reg[byte_addr[5:2]][{~byte_addr[1:0], 3'b000} +: 8] <= byte_data;
        end
        else if (cmd.start_block)
        begin
            a_reg <= h0_reg[0]; b_reg <= h0_reg[1]; c_reg <= h0_reg[2]; d_reg <= h0_reg[3];
            e_reg <= h0_reg[4]; f_reg <= h0_reg[5]; g_reg <= h0_reg[6]; h_reg <= h0_reg[7];
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++) h0_reg[i] <= INIT_H[i];
        end
        else if (cmd.reset_chain)
        begin
            for (int i = 0; i < 8; i++) h0_reg[i] <= INIT_H[i];
        end
        else if (cmd.fold)
        begin
            h0_reg[0] <= h0_reg[0] + a_reg; h0_reg[1] <= h0_reg[1] + b_reg;
            h0_reg[2] <= h0_reg[2] + c_reg; h0_reg[3] <= h0_reg[3] + d_reg;
            h0_reg[4] <= h0_reg[4] + e_reg; h0_reg[5] <= h0_reg[5] + f_reg;
            h0_reg[6] <= h0_reg[6] + g_reg; h0_reg[7] <= h0_reg[7] + h_reg;
        end
    end

    assign out_word = h0_reg[out_sel];

endmodule

FILE: rtl/sha256_ctrl.sv
// SHA-256 controller: byte intake, padding sequence, round counter, digest
// output. Depends on sha256_pkg.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_bvalid,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_num,
    output logic        out_last,
    output sha_cmd_t    cmd,
    output logic        byte_we,
    output logic [5:0]  byte_addr,
    output logic [7:0]  byte_data,
    output logic [5:0]  round_idx
);

    sha_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [60:0] len_reg, len_next;
    logic        closing_reg, closing_next;  // message end in progress
    logic        extra_reg, extra_next;      // a length-only block still follows
    logic        padded_reg, padded_next;    // 0x80 byte has gone out for this message
    logic [2:0]  num_reg, num_next;
    logic [63:0] bits;
    logic        accept;

    assign accept = in_valid && in_ready;
    assign bits = {len_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_bvalid && fill_reg == 6'd63) state_next = ST_LOAD;
                    else if (in_last) state_next = ST_PAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (cnt_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
            begin
                if (!closing_reg) state_next = ST_IDLE;
                else if (!padded_reg || extra_reg) state_next = ST_PAD;
                else state_next = ST_EMIT;
            end
            // pad sweep writes bytes fill..63 (0..63 for a length-only block), one per cycle
            ST_PAD:   if (cnt_reg == 6'd63) state_next = ST_LOAD;
            ST_EMIT:  if (out_ready && num_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        closing_next = closing_reg;
        extra_next = extra_reg;
        num_next = num_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_bvalid)
                    begin
                        fill_next = fill_reg + 6'd1;
                        len_next = len_reg + 61'd1;
                    end
                    closing_next = in_last;
                    cnt_next = in_bvalid ? fill_reg + 6'd1 : fill_reg;
                    if (in_bvalid && fill_reg == 6'd63) cnt_next = 6'd0;
                    extra_next = in_last && ((in_bvalid ? fill_reg + 6'd1 : fill_reg)
                                 >= LEN_START);
                end
            end
            ST_LOAD:  cnt_next = 6'd0;
            ST_ROUND: cnt_next = cnt_reg + 6'd1;
            ST_FOLD:
            begin
                // length-only block is swept from byte 0; otherwise from the fill
                cnt_next = padded_reg ? 6'd0 : fill_reg;
                if (closing_reg && extra_reg) extra_next = 1'b0;
            end
            ST_PAD:   cnt_next = cnt_reg + 6'd1;
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    num_next = num_reg + 3'd1;
                    if (num_reg == 3'd7)
                    begin
                        fill_next = 6'd0;
                        len_next = '0;
                        closing_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        byte_we = 1'b0;
        byte_addr = fill_reg;
        byte_data = in_byte;
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        case (state_reg)
            ST_IDLE:  byte_we = accept && in_bvalid;
            ST_LOAD:  cmd.start_block = 1'b1;
            ST_ROUND: cmd.round_en = 1'b1;
            ST_FOLD:  cmd.fold = 1'b1;
            ST_PAD:
            begin
                byte_we = 1'b1;
                byte_addr = cnt_reg;
                // pad byte only at the fill position of the first padded block
                if (cnt_reg == fill_reg && !padded_reg)
                    byte_data = PAD_BYTE;
                else if (cnt_reg >= LEN_START && !extra_reg)
                    byte_data = bits[8*(6'd63 - cnt_reg) +: 8];
                else
                    byte_data = 8'h00;
            end
            ST_EMIT:  cmd.reset_chain = out_ready && num_reg == 3'd7;
            default: ;
        endcase
    end

    always_comb
    begin
        padded_next = padded_reg;
        if (state_reg == ST_PAD && cnt_reg == fill_reg) padded_next = 1'b1;
        if (state_reg == ST_EMIT) padded_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            cnt_reg <= '0;
            len_reg <= '0;
            closing_reg <= 1'b0;
            extra_reg <= 1'b0;
            num_reg <= '0;
            padded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            closing_reg <= closing_next;
            extra_reg <= extra_next;
            num_reg <= num_next;
            padded_reg <= padded_next;
        end
    end

    assign round_idx = cnt_reg;
    assign out_num = num_reg;
    assign out_last = (num_reg == 3'd7);

endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// Channel  | Dir | Payload
// s_axis   | in  | tdata[7:0] data_byte; tuser[0] byte_valid; tlast end_of_message
// m_axis   | out | tdata[31:0] digest_word; tuser[2:0] word_number; tlast final_word
// One byte item per cycle while the controller is idle; a full block runs in the
// single round unit (load, 64 rounds, fold). End of message adds a pad sweep
// over bytes fill..63 and a block; a second sweep over all 64 bytes and a block
// follow when fill is 56 or more. Then 8 digest items.
// Reset (rst_n low, async) restores the initial hash and clears counters.
// m_axis stalls hold the digest; s_axis is not taken during blocks, padding or output.
// Top level; depends on sha256_pkg, sha256_ctrl, sha256_datapath.
module sha256_stream_hasher_top
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_number
    output logic        m_axis_tlast
);

    sha_cmd_t    cmd;
    logic        byte_we;
    logic [5:0]  byte_addr, round_idx;
    logic [7:0]  byte_data;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_bvalid (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_num   (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .byte_we   (byte_we),
        .byte_addr (byte_addr),
        .byte_data (byte_data),
        .round_idx (round_idx)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .byte_we   (byte_we),
        .byte_addr (byte_addr),
        .byte_data (byte_data),
        .round_idx (round_idx),
        .out_sel   (m_axis_tuser),
        .out_word  (m_axis_tdata)
    );

endmodule

FILE: dv/sha256_stream_hasher_top_tb.sv
// Self-checking testbench for sha256_stream_hasher_top: byte items in, digest words out.
// Digests are predicted by an in-bench SHA-256 model; depends on sha256_pkg and the RTL.
`timescale 1ns / 100ps

module sha256_stream_hasher_top_tb;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha256_stream_hasher_top DUT (.*);

    byte_item_t   pending_bytes[$];
    digest_item_t expected_digest[$];
    int           error_count = 0;
    bit           quiet_phase = 0;
    bit           hold_sender = 0;
    int           send_gap = 0;
    int           recv_gap = 0;

    // predictor state
    logic [31:0] hash_h[8];
    logic [7:0]  blk[64];
    int          fill;
    logic [60:0] byte_len;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_block();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic clear_hasher();
        for (int i = 0; i < 8; i++)
            hash_h[i] = INIT_H[i];
        for (int i = 0; i < 64; i++)
            blk[i] = '0;
        fill = 0;
        byte_len = '0;
    endtask

    task automatic predict_digest(byte_item_t it);
        logic [63:0] bits;
        digest_item_t r;
        if (it.byte_valid)
        begin
            blk[fill] = it.data_byte;
            fill = (fill + 1) % 64;
            byte_len = byte_len + 61'd1;
            if (fill == 0)
                hash_block();
        end
        if (!it.end_of_message)
            return;
        bits = {byte_len, 3'b000};
        for (int i = fill; i < 64; i++)
            blk[i] = '0;
        blk[fill] = PAD_BYTE;
        if (fill >= 56)
        begin
            hash_block();
            for (int i = 0; i < 64; i++)
                blk[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            blk[56+i] = bits[63-8*i -: 8];
        hash_block();
        for (int k = 0; k < 8; k++)
        begin
            r.digest_word = hash_h[k];
            r.word_number = k[2:0];
            r.final_word = (k == 7);
            expected_digest = {expected_digest, r};
        end
        clear_hasher();
    endtask

    function automatic byte_item_t mk(logic [7:0] d, logic v, logic e);
        byte_item_t it;
        it.data_byte = d;
        it.byte_valid = v;
        it.end_of_message = e;
        return it;
    endfunction

    task automatic enqueue_byte(byte_item_t it);
        pending_bytes = {pending_bytes, it};
    endtask

    // a message of n bytes, random content, with occasional idle items mixed in if idles is set
    task automatic queue_message(int n, bit close_with_byte, bit idles);
        for (int i = 0; i < n; i++)
        begin
            if (idles && $urandom_range(0, 9) == 0)
                enqueue_byte(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            enqueue_byte(mk(8'($urandom_range(0, 255)), 1'b1,
                            close_with_byte && i == n - 1));
        end
        if (!close_with_byte || n == 0)
            enqueue_byte(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                predict_digest(mk(s_axis_tdata, s_axis_tuser, s_axis_tlast));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 15) == 0)
            begin
                send_gap <= $urandom_range(1, 14) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0 && !hold_sender)
            begin
                byte_item_t it;
                it = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.data_byte;
                s_axis_tuser <= it.byte_valid;
                s_axis_tlast <= it.end_of_message;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_digest.size() == 0)
                begin
                    $error("unexpected digest item: word %0d = %h", m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    digest_item_t x;
                    x = expected_digest.pop_front();
                    if (m_axis_tdata !== x.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h", x.digest_word, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== x.word_number)
                    begin
                        $error("word_number: expected %0d, got %0d", x.word_number, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== x.final_word)
                    begin
                        $error("final_word: expected %0d, got %0d", x.final_word, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 11) == 0)
            begin
                recv_gap <= $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic drain();
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_digest.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_hasher();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle items, ignored bytes, short messages
        enqueue_byte(mk(8'hff, 1'b0, 1'b0));
        enqueue_byte(mk(8'h00, 1'b0, 1'b1));
        enqueue_byte(mk(8'hff, 1'b1, 1'b1));
        enqueue_byte(mk(8'h00, 1'b1, 1'b0));
        enqueue_byte(mk(8'h5a, 1'b0, 1'b0));
        enqueue_byte(mk(8'ha5, 1'b0, 1'b1));
        enqueue_byte(mk(8'h61, 1'b1, 1'b0));
        enqueue_byte(mk(8'h62, 1'b1, 1'b0));
        enqueue_byte(mk(8'h63, 1'b1, 1'b1));
        drain();

        // sender held off with items queued until every digest has come back
        queue_message(55, 1, 0);
        while (pending_bytes.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        hold_sender = 1;
        queue_message(56, 0, 0);
        while (expected_digest.size() > 0)
            @(posedge clk);
        hold_sender = 0;
        drain();
        queue_message(64, 1, 0);
        drain();

        // random short messages
        for (int m = 0; m < 12; m++)
            queue_message($urandom_range(0, 12), 1'($urandom_range(0, 1)), 1);
        drain();
        quiet_phase = 1;
        for (int m = 0; m < 3; m++)
            queue_message($urandom_range(0, 12), 1'($urandom_range(0, 1)), 1);
        drain();
        repeat (300) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher_top.sv
dv/sha256_stream_hasher_top_tb.sv
